@@ hdl/lbfl_pkg.sv @@
// ----------------------------------------------------------------------------
// lbfl_pkg
// Shared types, codes and constants of the linked block free-list manager.
// ----------------------------------------------------------------------------
package lbfl_pkg;

  // Default number of block entries held in the link memory
  localparam int unsigned LBFL_MAX_BLOCKS = 256;

  // Reset value of the volume size register
  localparam logic [7:0] BLOCKS_RESET = 8'd255;

  // Request opcodes
  typedef enum logic [2:0] {
    ACT_FORMAT     = 3'd0,
    ACT_ALLOC      = 3'd1,
    ACT_FREE       = 3'd2,
    ACT_FREE_CHAIN = 3'd3,
    ACT_LINK       = 3'd4,
    ACT_CHAIN_AT   = 3'd5,
    ACT_COUNT_FREE = 3'd6,
    ACT_UNUSED     = 3'd7
  } action_e;

  // Block type tags
  typedef enum logic [1:0] {
    TAG_INODE  = 2'd0,
    TAG_DATA   = 2'd1,
    TAG_FREE   = 2'd2,
    TAG_HOLDER = 2'd3
  } tag_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FMT,
    S_EVAL,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0] action;
    logic       block_type;
    logic [7:0] block_index;
    logic [7:0] link_target;
    logic [7:0] skip_count;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] block_result;
    logic [7:0] free_total;
  } out_t;

  // One link memory entry
  typedef struct packed {
    logic [1:0] tag;
    logic [7:0] next;
  } entry_t;

  // Link memory access from the controller
  typedef struct packed {
    logic [7:0] raddr;
    logic       we;
    logic [7:0] waddr;
    entry_t     wdata;
  } mem_req_t;

endpackage

@@ hdl/linked_block_free_list_manager_top.sv @@
// ----------------------------------------------------------------------------
// Free, errors found from the fields or the head, and an empty list need no
// link memory read; other requests read one block per chain step (alloc and
// link read one), and format writes one entry per block of the volume.
// One request in flight: the next is taken only after the result leaves the
// controller. Reset clears the head, controller state and output valid; link
// memory is undefined until format.
// ----------------------------------------------------------------------------
// linked_block_free_list_manager_top
// Block allocator with a linked free list kept in an on-chip link memory.
// ----------------------------------------------------------------------------
module linked_block_free_list_manager_top #(
  parameter int unsigned MAX_BLOCKS = lbfl_pkg::LBFL_MAX_BLOCKS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lbfl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lbfl_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_data_i
);
  import lbfl_pkg::*;

  logic [7:0] blocks_q;
  logic       res_valid, res_ready;
  out_t       res;
  mem_req_t   mem_req;
  entry_t     mem_rdata;
  logic       out_valid_q;
  out_t       out_data_q;

  // Volume size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q <= BLOCKS_RESET;
    end else if (cfg_we_i) begin
      blocks_q <= cfg_data_i;
    end
  end

  lbfl_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blocks_i    (blocks_q),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  lbfl_mem #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Failed requests carry no block and no count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      (out_data_o.block_result == 8'd0) && (out_data_o.free_total == 8'd0))
    else $error("error result with nonzero fields");

  // An accepted request keeps the controller busy in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a request is in progress");

  // A finished result reaches the output register
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> out_valid_o && (out_data_o == $past(res)))
    else $error("result lost on the way to the output");

endmodule

@@ hdl/lbfl_mem.sv @@
// ----------------------------------------------------------------------------
// lbfl_mem
// Link memory: tag and next pointer per block, one read and one write port,
// registered read data with write-to-read forwarding on the same address.
// ----------------------------------------------------------------------------
module lbfl_mem #(
  parameter int unsigned MAX_BLOCKS = lbfl_pkg::LBFL_MAX_BLOCKS
) (
  input  logic               clk_i,
  input  lbfl_pkg::mem_req_t req_i,
  output lbfl_pkg::entry_t   rdata_o
);
  import lbfl_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);

  entry_t ram [MAX_BLOCKS];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      ram[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
  end

  // Read port, new data wins on a same-address collision
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rdata_q <= req_i.wdata;
    end else begin
      rdata_q <= ram[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lbfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbfl_ctrl
// Request sequencer: holds the free-list head, walks chains through the link
// memory one block per cycle and builds the result of each request.
// ----------------------------------------------------------------------------
module lbfl_ctrl #(
  parameter int unsigned MAX_BLOCKS = lbfl_pkg::LBFL_MAX_BLOCKS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         blocks_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  lbfl_pkg::in_t      req_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output lbfl_pkg::out_t     res_o,
  output lbfl_pkg::mem_req_t mem_req_o,
  input  lbfl_pkg::entry_t   mem_rdata_i
);
  import lbfl_pkg::*;

  localparam logic [8:0] MaxN = 9'(MAX_BLOCKS);

  state_e     state_q, state_d;
  logic [2:0] act_q, act_d;
  logic       type_q, type_d;
  logic [7:0] target_q, target_d;
  logic [7:0] cur_q, cur_d;
  logic [8:0] cnt_q, cnt_d;
  logic [7:0] head_q, head_d;
  logic [7:0] fi_q, fi_d;
  out_t       res_q, res_d;

  logic       fin, go_eval, go_fmt;
  logic [8:0] n;
  logic [8:0] fi_inc;
  logic [8:0] cnt_inc;
  logic [7:0] nx;

  // Block lies inside the volume, block zero excluded
  function automatic logic in_vol(input logic [7:0] b, input logic [8:0] size);
    return (b != 8'd0) && ({1'b0, b} < size);
  endfunction

  // Volume size in effect
  assign n       = ({1'b0, blocks_i} > MaxN) ? MaxN : {1'b0, blocks_i};
  assign fi_inc  = {1'b0, fi_q} + 9'd1;
  assign cnt_inc = cnt_q + 9'd1;
  assign nx      = mem_rdata_i.next;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

  // Datapath and memory access
  always_comb begin
    act_d     = act_q;
    type_d    = type_q;
    target_d  = target_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    head_d    = head_q;
    fi_d      = fi_q;
    res_d     = res_q;
    mem_req_o = '0;
    fin       = 1'b0;
    go_eval   = 1'b0;
    go_fmt    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          act_d    = req_i.action;
          type_d   = req_i.block_type;
          target_d = req_i.link_target;
          res_d    = '{status: ST_BAD, block_result: 8'd0, free_total: 8'd0};
          case (req_i.action)
            ACT_FORMAT: begin
              if (n < 9'd2) begin
                fin = 1'b1;
              end else begin
                fi_d   = 8'd0;
                go_fmt = 1'b1;
              end
            end
            ACT_ALLOC: begin
              cur_d = head_q;
              if (head_q == 8'd0) begin
                fin          = 1'b1;
                res_d.status = ST_NO_SPACE;
              end else if ({1'b0, head_q} >= n) begin
                fin = 1'b1;
              end else begin
                mem_req_o.raddr = head_q;
                go_eval         = 1'b1;
              end
            end
            ACT_FREE: begin
              fin = 1'b1;
              if (in_vol(req_i.block_index, n)) begin
                mem_req_o.we         = 1'b1;
                mem_req_o.waddr      = req_i.block_index;
                mem_req_o.wdata.tag  = TAG_FREE;
                mem_req_o.wdata.next = head_q;
                head_d               = req_i.block_index;
                res_d.status         = ST_OK;
              end
            end
            ACT_FREE_CHAIN, ACT_LINK: begin
              cur_d = req_i.block_index;
              if ((req_i.action == ACT_FREE_CHAIN) && (req_i.block_index == 8'd0)) begin
                fin          = 1'b1;
                res_d.status = ST_OK;
              end else if (!in_vol(req_i.block_index, n)) begin
                fin = 1'b1;
              end else begin
                mem_req_o.raddr = req_i.block_index;
                go_eval         = 1'b1;
              end
            end
            ACT_CHAIN_AT: begin
              cur_d = req_i.block_index;
              cnt_d = {1'b0, req_i.skip_count};
              if (req_i.skip_count == 8'd0) begin
                fin = 1'b1;
                if (in_vol(req_i.block_index, n)) begin
                  res_d.status       = ST_OK;
                  res_d.block_result = req_i.block_index;
                end
              end else if (!in_vol(req_i.block_index, n)) begin
                fin = 1'b1;
              end else begin
                mem_req_o.raddr = req_i.block_index;
                go_eval         = 1'b1;
              end
            end
            ACT_COUNT_FREE: begin
              cur_d = head_q;
              cnt_d = 9'd0;
              if (head_q == 8'd0) begin
                fin          = 1'b1;
                res_d.status = ST_OK;
              end else if (!in_vol(head_q, n)) begin
                fin = 1'b1;
              end else begin
                mem_req_o.raddr = head_q;
                go_eval         = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Format sweep, one entry per cycle
      S_FMT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = fi_q;
        if (fi_q == 8'd0) begin
          mem_req_o.wdata.tag  = TAG_HOLDER;
          mem_req_o.wdata.next = 8'd0;
        end else begin
          mem_req_o.wdata.tag  = TAG_FREE;
          mem_req_o.wdata.next = (fi_inc < n) ? fi_inc[7:0] : 8'd0;
        end
        fi_d = fi_inc[7:0];
        if (fi_inc == n) begin
          head_d       = 8'd1;
          fin          = 1'b1;
          res_d.status = ST_OK;
        end
      end

      // Entry of cur_q is on the read port
      S_EVAL: begin
        case (act_q)
          ACT_ALLOC: begin
            fin = 1'b1;
            if (mem_rdata_i.tag == TAG_FREE) begin
              head_d               = nx;
              mem_req_o.we         = 1'b1;
              mem_req_o.waddr      = cur_q;
              mem_req_o.wdata.tag  = {1'b0, type_q};
              mem_req_o.wdata.next = 8'd0;
              res_d.status         = ST_OK;
              res_d.block_result   = cur_q;
            end
          end
          ACT_FREE_CHAIN: begin
            if (mem_rdata_i.tag != TAG_DATA) begin
              fin = 1'b1;
            end else begin
              mem_req_o.we         = 1'b1;
              mem_req_o.waddr      = cur_q;
              mem_req_o.wdata.tag  = TAG_FREE;
              mem_req_o.wdata.next = head_q;
              head_d               = cur_q;
              cur_d                = nx;
              if (nx == 8'd0) begin
                fin          = 1'b1;
                res_d.status = ST_OK;
              end else if (!in_vol(nx, n)) begin
                fin = 1'b1;
              end else begin
                mem_req_o.raddr = nx;
                go_eval         = 1'b1;
              end
            end
          end
          ACT_LINK: begin
            fin = 1'b1;
            if (mem_rdata_i.tag == TAG_DATA) begin
              mem_req_o.we         = 1'b1;
              mem_req_o.waddr      = cur_q;
              mem_req_o.wdata.tag  = TAG_DATA;
              mem_req_o.wdata.next = target_q;
              res_d.status         = ST_OK;
            end
          end
          ACT_CHAIN_AT: begin
            if (mem_rdata_i.tag != TAG_DATA) begin
              fin = 1'b1;
            end else begin
              cur_d = nx;
              cnt_d = cnt_q - 9'd1;
              if (cnt_q == 9'd1) begin
                fin = 1'b1;
                if (in_vol(nx, n)) begin
                  res_d.status       = ST_OK;
                  res_d.block_result = nx;
                end
              end else if (!in_vol(nx, n)) begin
                fin = 1'b1;
              end else begin
                mem_req_o.raddr = nx;
                go_eval         = 1'b1;
              end
            end
          end
          ACT_COUNT_FREE: begin
            if ((mem_rdata_i.tag != TAG_FREE) || (cnt_inc > {1'b0, blocks_i})) begin
              fin = 1'b1;
            end else begin
              cnt_d = cnt_inc;
              cur_d = nx;
              if (nx == 8'd0) begin
                fin              = 1'b1;
                res_d.status     = ST_OK;
                res_d.free_total = cnt_inc[7:0];
              end else if (!in_vol(nx, n)) begin
                fin = 1'b1;
              end else begin
                mem_req_o.raddr = nx;
                go_eval         = 1'b1;
              end
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (fin)         state_d = S_EMIT;
          else if (go_fmt) state_d = S_FMT;
          else             state_d = S_EVAL;
        end
      end
      S_FMT: begin
        if (fin) state_d = S_EMIT;
      end
      S_EVAL: begin
        if (!go_eval) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= 8'd0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    type_q   <= type_d;
    target_q <= target_d;
    cur_q    <= cur_d;
    cnt_q    <= cnt_d;
    fi_q     <= fi_d;
    res_q    <= res_d;
  end

endmodule
